/* rtl/core/ibar_pkg.sv */
// ----------------------------------------------------------------------------
// ibar_pkg
// Shared types and constants of the image border address resolver.
// ----------------------------------------------------------------------------
package ibar_pkg;

  localparam int DIM_W      = 13;  // image width / height register
  localparam int SMALL_W    = 3;   // channel count, bytes per channel
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int COORD_W    = 16;
  localparam int CHAN_W     = 2;
  localparam int RES_W      = 12;
  localparam int OFS_W      = 28;

  typedef enum logic [MODE_W-1:0] {
    BM_ZERO   = 2'd0,
    BM_MIRROR = 2'd1,
    BM_REPEAT = 2'd2,
    BM_WRAP   = 2'd3
  } border_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_CHANS  = 3'd2,
    CFG_BPC    = 3'd3,
    CFG_MODE   = 3'd4
  } cfg_idx_e;

  // effective (already clamped) configuration
  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [SMALL_W-1:0] chans;
    logic [SMALL_W-1:0] bpc;
    border_mode_e       mode;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [CHAN_W-1:0]         channel_index;
  } in_word_t;

  typedef struct packed {
    logic              inside_res;
    logic              fault;
    logic [RES_W-1:0]  resolved_x;
    logic [RES_W-1:0]  resolved_y;
    logic [OFS_W-1:0]  byte_offset;
  } out_word_t;

  typedef struct packed {
    logic wrap;  // result still needs the wrap remainder
    logic neg;   // coordinate was negative
  } axis_flags_t;

  typedef struct packed {
    logic hit;
    logic fault;
  } res_flags_t;

endpackage

/* rtl/core/ibar_cfg.sv */
// ----------------------------------------------------------------------------
// ibar_cfg
// Configuration registers; values are clamped to their legal range on write.
// ----------------------------------------------------------------------------
module ibar_cfg import ibar_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [CFG_IDX_W-1:0]  idx_i,
  input  logic [CFG_DATA_W-1:0] data_i,
  output cfg_t                  cfg_o
);

  logic [DIM_W-1:0]   width_q, width_d;
  logic [DIM_W-1:0]   height_q, height_d;
  logic [SMALL_W-1:0] chans_q, chans_d;
  logic [SMALL_W-1:0] bpc_q, bpc_d;
  border_mode_e       mode_q, mode_d;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [SMALL_W-1:0] clamp_small(logic [SMALL_W-1:0] v);
    logic [SMALL_W-1:0] r;
    if (v == '0) begin
      r = SMALL_W'(1);
    end else if (v > SMALL_W'(4)) begin
      r = SMALL_W'(4);
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    chans_d  = chans_q;
    bpc_d    = bpc_q;
    mode_d   = mode_q;
    if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CFG_WIDTH:  width_d  = clamp_dim(data_i[DIM_W-1:0]);
        CFG_HEIGHT: height_d = clamp_dim(data_i[DIM_W-1:0]);
        CFG_CHANS:  chans_d  = clamp_small(data_i[SMALL_W-1:0]);
        CFG_BPC:    bpc_d    = clamp_small(data_i[SMALL_W-1:0]);
        CFG_MODE:   mode_d   = border_mode_e'(data_i[MODE_W-1:0]);
        default: ;  // no register there
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      chans_q  <= SMALL_W'(1);
      bpc_q    <= SMALL_W'(1);
      mode_q   <= BM_ZERO;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      chans_q  <= chans_d;
      bpc_q    <= bpc_d;
      mode_q   <= mode_d;
    end
  end

  assign cfg_o = '{width: width_q, height: height_q, chans: chans_q,
                   bpc: bpc_q, mode: mode_q};

  ap_mode_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_i && idx_i == CFG_MODE) |=> cfg_o.mode == $past(data_i[MODE_W-1:0]))
    else $error("border mode write not taken");

endmodule

/* rtl/core/ibar_classify.sv */
// ----------------------------------------------------------------------------
// ibar_classify
// Input register and per-axis border classification (two stages).
// ----------------------------------------------------------------------------
module ibar_classify import ibar_pkg::*; #(
  parameter int MAX_DIM    = 4096,
  parameter int COORD_BITS = 16,
  localparam int RW = ($clog2(MAX_DIM) < DIM_W) ? $clog2(MAX_DIM) : DIM_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] x_mag_o,
  output logic [COORD_BITS-1:0] y_mag_o,
  output logic [RW-1:0]         x_pre_o,
  output logic [RW-1:0]         y_pre_o,
  output axis_flags_t           x_flags_o,
  output axis_flags_t           y_flags_o,
  output res_flags_t            flags_o,
  output logic [CHAN_W-1:0]     chan_o
);

  localparam int EW = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 2;
  localparam logic signed [EW-1:0] E_ONE = EW'(1);

  typedef enum logic [1:0] {AX_OK, AX_NONE, AX_FAULT} axis_st_e;

  typedef struct packed {
    axis_st_e              st;
    logic [RW-1:0]         res;
    axis_flags_t           fl;
    logic [COORD_BITS-1:0] mag;
  } axis_t;

  function automatic axis_t classify_axis(logic [COORD_BITS-1:0] raw,
                                          logic [DIM_W-1:0] s,
                                          border_mode_e mode);
    logic signed [EW-1:0] ie;
    logic signed [EW-1:0] se;
    logic signed [EW-1:0] mir;
    logic                 neg;
    logic                 in_img;
    logic                 mir_ok;
    axis_t                a;
    ie     = EW'($signed(raw));
    se     = $signed(EW'(s));
    neg    = raw[COORD_BITS-1];
    in_img = !neg && (ie < se);
    // one reflection, edge not repeated
    mir    = neg ? -ie : (((se - E_ONE) <<< 1) - ie);
    mir_ok = !mir[EW-1] && (mir < se);
    a.mag     = COORD_BITS'(neg ? -ie : ie);
    a.fl.neg  = neg;
    a.fl.wrap = 1'b0;
    a.res     = '0;
    a.st      = AX_NONE;
    if (in_img) begin
      a.st  = AX_OK;
      a.res = RW'(ie);
    end else begin
      case (mode)
        BM_ZERO:   a.st = AX_NONE;
        BM_MIRROR: begin
          a.st  = mir_ok ? AX_OK : AX_FAULT;
          a.res = RW'(mir);
        end
        BM_REPEAT: begin
          a.st  = AX_OK;
          a.res = neg ? '0 : RW'(s - DIM_W'(1));
        end
        BM_WRAP: begin
          a.st      = AX_OK;
          a.fl.wrap = 1'b1;
        end
        default:   a.st = AX_NONE;
      endcase
    end
    return a;
  endfunction

  logic              in0_vld_q;
  in_word_t          in0_q;
  logic              cls_vld_q;
  axis_t             x_q, x_d, y_q, y_d;
  res_flags_t        fl_q, fl_d;
  logic [CHAN_W-1:0] chan_q;
  logic              rdy0, rdy1;

  assign rdy1       = !cls_vld_q || out_ready_i;
  assign rdy0       = !in0_vld_q || rdy1;
  assign in_ready_o = rdy0;

  always_comb begin
    x_d = classify_axis(COORD_BITS'($unsigned(in0_q.coord_x)), cfg_i.width, cfg_i.mode);
    y_d = classify_axis(COORD_BITS'($unsigned(in0_q.coord_y)), cfg_i.height, cfg_i.mode);
    if ({1'b0, in0_q.channel_index} >= cfg_i.chans) begin
      fl_d = '{hit: 1'b0, fault: 1'b1};
    end else if (x_d.st != AX_OK) begin
      // x failed: y is not looked at
      fl_d = '{hit: 1'b0, fault: (x_d.st == AX_FAULT)};
    end else begin
      fl_d = '{hit: (y_d.st == AX_OK), fault: (y_d.st == AX_FAULT)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in0_vld_q <= 1'b0;
      cls_vld_q <= 1'b0;
    end else begin
      if (rdy0) begin
        in0_vld_q <= in_valid_i;
      end
      if (rdy1) begin
        cls_vld_q <= in0_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      in0_q <= in_word_i;
    end
    if (rdy1 && in0_vld_q) begin
      x_q    <= x_d;
      y_q    <= y_d;
      fl_q   <= fl_d;
      chan_q <= in0_q.channel_index;
    end
  end

  assign out_valid_o = cls_vld_q;
  assign x_mag_o     = x_q.mag;
  assign y_mag_o     = y_q.mag;
  assign x_pre_o     = x_q.res;
  assign y_pre_o     = y_q.res;
  assign x_flags_o   = x_q.fl;
  assign y_flags_o   = y_q.fl;
  assign flags_o     = fl_q;
  assign chan_o      = chan_q;

  ap_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cls_vld_q |-> !(fl_q.hit && fl_q.fault))
    else $error("word marked both inside and faulted");

endmodule

/* rtl/core/ibar_mod_pipe.sv */
// ----------------------------------------------------------------------------
// ibar_mod_pipe
// Restoring remainder pipeline, one numerator bit per stage, both axes in
// lockstep; a sideband vector travels alongside.
// ----------------------------------------------------------------------------
module ibar_mod_pipe import ibar_pkg::*; #(
  parameter int NUM_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [NUM_W-1:0]  x_num_i,
  input  logic [NUM_W-1:0]  y_num_i,
  input  logic [DIM_W-1:0]  x_den_i,
  input  logic [DIM_W-1:0]  y_den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DIM_W-1:0]  x_rem_o,
  output logic [DIM_W-1:0]  y_rem_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [NUM_W-1:0]  vld_q, vld_f;
  logic [NUM_W:0]    rdy;
  logic [DIM_W-1:0]  xr_q [NUM_W];
  logic [DIM_W-1:0]  xr_f [NUM_W];
  logic [DIM_W-1:0]  xr_d [NUM_W];
  logic [DIM_W-1:0]  yr_q [NUM_W];
  logic [DIM_W-1:0]  yr_f [NUM_W];
  logic [DIM_W-1:0]  yr_d [NUM_W];
  logic [NUM_W-1:0]  xn_q [NUM_W];
  logic [NUM_W-1:0]  xn_f [NUM_W];
  logic [NUM_W-1:0]  xn_d [NUM_W];
  logic [NUM_W-1:0]  yn_q [NUM_W];
  logic [NUM_W-1:0]  yn_f [NUM_W];
  logic [NUM_W-1:0]  yn_d [NUM_W];
  logic [SIDE_W-1:0] sd_q [NUM_W];
  logic [SIDE_W-1:0] sd_f [NUM_W];

  // remainder stays below d, so one compare and subtract per bit
  function automatic logic [DIM_W-1:0] rem_step(logic [DIM_W-1:0] r, logic b,
                                                logic [DIM_W-1:0] d);
    logic [DIM_W:0]   t;
    logic [DIM_W-1:0] q;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      q = DIM_W'(t - {1'b0, d});
    end else begin
      q = DIM_W'(t);
    end
    return q;
  endfunction

  always_comb begin
    vld_f[0] = in_valid_i;
    xr_f[0]  = '0;
    yr_f[0]  = '0;
    xn_f[0]  = x_num_i;
    yn_f[0]  = y_num_i;
    sd_f[0]  = side_i;
    for (int k = 1; k < NUM_W; k++) begin
      vld_f[k] = vld_q[k-1];
      xr_f[k]  = xr_q[k-1];
      yr_f[k]  = yr_q[k-1];
      xn_f[k]  = xn_q[k-1];
      yn_f[k]  = yn_q[k-1];
      sd_f[k]  = sd_q[k-1];
    end
    for (int k = 0; k < NUM_W; k++) begin
      xr_d[k] = rem_step(xr_f[k], xn_f[k][NUM_W-1], x_den_i);
      yr_d[k] = rem_step(yr_f[k], yn_f[k][NUM_W-1], y_den_i);
      xn_d[k] = {xn_f[k][NUM_W-2:0], 1'b0};
      yn_d[k] = {yn_f[k][NUM_W-2:0], 1'b0};
    end
  end

  // a stage takes a word when empty or when its own word moves on
  assign rdy[NUM_W] = out_ready_i;
  for (genvar k = 0; k < NUM_W; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NUM_W; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_f[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_W; k++) begin
      if (rdy[k] && vld_f[k]) begin
        xr_q[k] <= xr_d[k];
        yr_q[k] <= yr_d[k];
        xn_q[k] <= xn_d[k];
        yn_q[k] <= yn_d[k];
        sd_q[k] <= sd_f[k];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NUM_W-1];
  assign x_rem_o     = xr_q[NUM_W-1];
  assign y_rem_o     = yr_q[NUM_W-1];
  assign side_o      = sd_q[NUM_W-1];

  ap_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("remainder pipe refuses input with a free stage");

  ap_first_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted word lost at first stage");

endmodule

/* rtl/core/ibar_addr.sv */
// ----------------------------------------------------------------------------
// ibar_addr
// Byte offset ((y*w+x)*ch+c)*bpc over three stages plus an output register.
// ----------------------------------------------------------------------------
module ibar_addr import ibar_pkg::*; #(
  parameter int MAX_DIM = 4096,
  localparam int RW = ($clog2(MAX_DIM) < DIM_W) ? $clog2(MAX_DIM) : DIM_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  res_flags_t        flags_i,
  input  logic [RW-1:0]     rx_i,
  input  logic [RW-1:0]     ry_i,
  input  logic [CHAN_W-1:0] chan_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_word_o
);

  localparam int LIN_W = RW + DIM_W + 1;
  localparam int LC_W  = LIN_W + 2;
  localparam int OW    = LC_W + 2;

  logic              a_vld_q, b_vld_q, c_vld_q, o_vld_q;
  logic              rdy_a, rdy_b, rdy_c, rdy_o;
  res_flags_t        a_fl_q, b_fl_q, c_fl_q;
  logic [RW-1:0]     a_rx_q, b_rx_q, c_rx_q;
  logic [RW-1:0]     a_ry_q, b_ry_q, c_ry_q;
  logic [CHAN_W-1:0] a_ch_q, b_ch_q;
  logic [LIN_W-1:0]  b_lin_q, b_lin_d;
  logic [LC_W-1:0]   c_lc_q, c_lc_d;
  logic [OW-1:0]     off;
  out_word_t         out_q, out_d;

  assign rdy_o      = !o_vld_q || out_ready_i;
  assign rdy_c      = !c_vld_q || rdy_o;
  assign rdy_b      = !b_vld_q || rdy_c;
  assign rdy_a      = !a_vld_q || rdy_b;
  assign in_ready_o = rdy_a;

  assign b_lin_d = LIN_W'(a_ry_q) * LIN_W'(cfg_i.width) + LIN_W'(a_rx_q);
  assign c_lc_d  = LC_W'(b_lin_q) * LC_W'(cfg_i.chans) + LC_W'(b_ch_q);
  assign off     = OW'(c_lc_q) * OW'(cfg_i.bpc);

  always_comb begin
    out_d = '0;
    out_d.fault = c_fl_q.fault;
    if (c_fl_q.hit) begin
      out_d.inside_res  = 1'b1;
      out_d.resolved_x  = RES_W'(c_rx_q);
      out_d.resolved_y  = RES_W'(c_ry_q);
      out_d.byte_offset = OFS_W'(off);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (rdy_a) a_vld_q <= in_valid_i;
      if (rdy_b) b_vld_q <= a_vld_q;
      if (rdy_c) c_vld_q <= b_vld_q;
      if (rdy_o) o_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      a_fl_q <= flags_i;
      a_rx_q <= rx_i;
      a_ry_q <= ry_i;
      a_ch_q <= chan_i;
    end
    if (rdy_b && a_vld_q) begin
      b_fl_q  <= a_fl_q;
      b_rx_q  <= a_rx_q;
      b_ry_q  <= a_ry_q;
      b_ch_q  <= a_ch_q;
      b_lin_q <= b_lin_d;
    end
    if (rdy_c && b_vld_q) begin
      c_fl_q <= b_fl_q;
      c_rx_q <= b_rx_q;
      c_ry_q <= b_ry_q;
      c_lc_q <= c_lc_d;
    end
    if (rdy_o && c_vld_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = o_vld_q;
  assign out_word_o  = out_q;

  ap_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("address stages refuse input with a free stage");

endmodule

/* rtl/core/image_border_address_resolver_core.sv */
// ----------------------------------------------------------------------------
// image_border_address_resolver_core
// Resolves a signed pixel coordinate against the image border rule and
// returns the resolved pixel and the byte offset of one channel value.
// ----------------------------------------------------------------------------
//  port group   direction  handshake                 word
//  in_*         in         in_valid_i / in_ready_o   in_word_t
//  out_*        out        out_valid_o / out_ready_i out_word_t
//  cfg_*        in         cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
//  One word per cycle unless the output stalls; every word passes the remainder
//  pipeline (one coordinate bit per stage) used for wrap mode.
//  Reset clears all stage valids and sets width, height, channels and bytes
//  per channel to 1, border mode to zero.
//  A stalled output holds its stage; upstream stages keep filling bubbles.
// ----------------------------------------------------------------------------
module image_border_address_resolver_core import ibar_pkg::*; #(
  parameter int MAX_DIM    = 4096,
  parameter int COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int RW = ($clog2(MAX_DIM) < DIM_W) ? $clog2(MAX_DIM) : DIM_W;

  typedef struct packed {
    logic [RW-1:0]     x_pre;
    logic [RW-1:0]     y_pre;
    axis_flags_t       x_fl;
    axis_flags_t       y_fl;
    res_flags_t        fl;
    logic [CHAN_W-1:0] chan;
  } side_t;

  localparam int SIDE_W = $bits(side_t);

  cfg_t                  cfg;
  logic                  cls_valid, cls_ready;
  logic [COORD_BITS-1:0] x_mag, y_mag;
  side_t                 cls_side, mod_side;
  logic                  mod_valid, mod_ready;
  logic [DIM_W-1:0]      x_rem, y_rem;
  logic [RW-1:0]         rx, ry;

  // negative coordinate: count back from the far edge, exact multiple gives 0
  function automatic logic [RW-1:0] wrap_fix(logic [DIM_W-1:0] r,
                                             logic [DIM_W-1:0] s, logic neg);
    logic [RW-1:0] v;
    if (neg && r != '0) begin
      v = RW'(s - r);
    end else begin
      v = RW'(r);
    end
    return v;
  endfunction

  ibar_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  ibar_classify #(
    .MAX_DIM    (MAX_DIM),
    .COORD_BITS (COORD_BITS)
  ) u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (cls_valid),
    .out_ready_i (cls_ready),
    .x_mag_o     (x_mag),
    .y_mag_o     (y_mag),
    .x_pre_o     (cls_side.x_pre),
    .y_pre_o     (cls_side.y_pre),
    .x_flags_o   (cls_side.x_fl),
    .y_flags_o   (cls_side.y_fl),
    .flags_o     (cls_side.fl),
    .chan_o      (cls_side.chan)
  );

  ibar_mod_pipe #(
    .NUM_W  (COORD_BITS),
    .SIDE_W (SIDE_W)
  ) u_mod_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cls_valid),
    .in_ready_o  (cls_ready),
    .x_num_i     (x_mag),
    .y_num_i     (y_mag),
    .x_den_i     (cfg.width),
    .y_den_i     (cfg.height),
    .side_i      (cls_side),
    .out_valid_o (mod_valid),
    .out_ready_i (mod_ready),
    .x_rem_o     (x_rem),
    .y_rem_o     (y_rem),
    .side_o      (mod_side)
  );

  always_comb begin
    rx = mod_side.x_fl.wrap ? wrap_fix(x_rem, cfg.width, mod_side.x_fl.neg)
                            : mod_side.x_pre;
    ry = mod_side.y_fl.wrap ? wrap_fix(y_rem, cfg.height, mod_side.y_fl.neg)
                            : mod_side.y_pre;
  end

  ibar_addr #(
    .MAX_DIM (MAX_DIM)
  ) u_addr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (mod_valid),
    .in_ready_o  (mod_ready),
    .flags_i     (mod_side.fl),
    .rx_i        (rx),
    .ry_i        (ry),
    .chan_i      (mod_side.chan),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
